### design/lph_pkg.sv
// Shared types and constants for the linear probing hash table.
package lph_pkg;

	localparam int KEY_W  = 31;
	localparam int SIZE_W = 11;
	localparam int SLOT_W = 10;
	localparam int CNT_W  = $clog2(KEY_W + 1);

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// request codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// result codes
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} entry_t;

endpackage

### design/linear_probe_hash_table.sv
// Linear probing hash table: request control, home slot hashing and probe pipeline.
// Flow: a request is accepted, a serial unit works out the key mod size remainder,
//   then the probe reads one slot per cycle in probe order, checks each returned
//   slot and hands the result over.
// One request at a time: a new request is taken only once the last result is in the
//   output register. A waiting result does not block a new request.
// Reset: arst_n clears control state and table_size to 1024, then a clearing pass
//   empties every slot while in_ready stays low.
module linear_probe_hash_table #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [lph_pkg::KEY_W-1:0]     key_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic [lph_pkg::SLOT_W-1:0]    slot_index,
	input  logic                          cfg_wr_en,
	input  logic [lph_pkg::SIZE_W-1:0]    cfg_wr_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = AW + 1;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_HASH  = 5'b00100,
		ST_PROBE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                        state_q;
	logic [lph_pkg::SIZE_W-1:0]    table_size_q;
	logic [AW-1:0]                 clr_q;
	logic [LW-1:0]                 issue_cnt_q;
	logic                          out_valid_q;
	logic                          chk_valid_s1;
	logic [AW-1:0]                 chk_addr_s1;

	// request context, held for the whole probe
	logic [1:0]                    op_q;
	logic [lph_pkg::KEY_W-1:0]     key_q;
	logic [LW-1:0]                 size_q;
	logic [AW-1:0]                 pos_q;
	logic                          res_status_q;
	logic [lph_pkg::SLOT_W-1:0]    res_slot_q;
	logic                          out_status_q;
	logic [lph_pkg::SLOT_W-1:0]    out_slot_q;

	logic                          accept;
	logic                          op_known;
	logic [LW-1:0]                 live_size;
	logic                          div_done;
	logic [LW-1:0]                 div_rem;
	logic [LW-1:0]                 pos_inc;
	logic [AW-1:0]                 pos_next;
	logic                          hit;
	logic                          probe_miss;
	logic                          out_load;
	logic [31:0]                   slot_ext;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	lph_pkg::entry_t               mem_wdata;
	logic                          mem_re;
	lph_pkg::entry_t               mem_rdata;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign op_known = (req_type == lph_pkg::OP_INSERT) || (req_type == lph_pkg::OP_SEARCH) ||
		(req_type == lph_pkg::OP_DELETE);

	// clamp the configured size into 1 .. TABLE_DEPTH
	always_comb begin
		priority if (table_size_q == '0) begin
			live_size = LW'(1);
		end else if (32'(table_size_q) > 32'(TABLE_DEPTH)) begin
			live_size = LW'(TABLE_DEPTH);
		end else begin
			live_size = LW'(table_size_q);
		end
	end

	lph_div #(
		.DW (LW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && op_known),
		.dividend  (key_value),
		.divisor   (live_size),
		.done      (div_done),
		.remainder (div_rem)
	);

	// next probe position, wrapping at the live size
	assign pos_inc  = {1'b0, pos_q} + LW'(1);
	assign pos_next = (pos_inc >= size_q) ? '0 : pos_inc[AW-1:0];

	// check the slot whose read data has just come back
	always_comb begin
		hit = 1'b0;
		if (state_q == ST_PROBE && chk_valid_s1) begin
			if (op_q == lph_pkg::OP_INSERT) begin
				hit = !mem_rdata.valid;
			end else begin
				hit = mem_rdata.valid && (mem_rdata.key == key_q);
			end
		end
	end

	assign mem_re     = (state_q == ST_PROBE) && (issue_cnt_q < size_q) && !hit;
	assign probe_miss = (state_q == ST_PROBE) && (issue_cnt_q == size_q) && !chk_valid_s1;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign slot_ext   = 32'(chk_addr_s1);

	// clearing pass writes empty entries; a hit writes the new or removed entry
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = chk_addr_s1;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if (hit && op_q != lph_pkg::OP_SEARCH) begin
			mem_we = 1'b1;
			if (op_q == lph_pkg::OP_INSERT) begin
				mem_wdata.valid = 1'b1;
				mem_wdata.key   = key_q;
			end
		end
	end

	lph_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (pos_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			table_size_q <= lph_pkg::SIZE_RESET;
			clr_q        <= '0;
			issue_cnt_q  <= '0;
			out_valid_q  <= 1'b0;
			chk_valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				table_size_q <= cfg_wr_data;
			end
			chk_valid_s1 <= mem_re;
			// raise valid on a new result, drop it once the consumer has taken it
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= op_known ? ST_HASH : ST_DONE;
					end
				end
				ST_HASH: begin
					if (div_done) begin
						issue_cnt_q <= '0;
						state_q     <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (hit || probe_miss) begin
						state_q <= ST_DONE;
					end else if (mem_re) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req_type;
			key_q        <= key_value;
			size_q       <= live_size;
			res_status_q <= lph_pkg::ST_FAIL;
			res_slot_q   <= '0;
		end
		if (state_q == ST_HASH && div_done) begin
			pos_q <= div_rem[AW-1:0];
		end else if (mem_re) begin
			pos_q <= pos_next;
		end
		chk_addr_s1 <= pos_q;
		if (hit) begin
			res_status_q <= lph_pkg::ST_OK;
			res_slot_q   <= slot_ext[lph_pkg::SLOT_W-1:0];
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign slot_index = out_slot_q;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == pos_q)))
		else $error("slot written and read in the same cycle");

	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_status_q == lph_pkg::ST_OK || out_slot_q == '0))
		else $error("failed request carries a non-zero slot");

	a_div_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_HASH))
		else $error("remainder finished outside the hash phase");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (issue_cnt_q <= size_q))
		else $error("probe read more slots than the live size");

	a_write_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != ST_CLEAR) |-> hit)
		else $error("slot store written without a matching probe");

endmodule

### design/lph_div.sv
// Bit-serial restoring remainder unit: key mod table size, one bit a cycle.
module lph_div #(
	parameter int DW = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lph_pkg::KEY_W-1:0] dividend,
	input  logic [DW-1:0]            divisor,
	output logic                     done,
	output logic [DW-1:0]            remainder
);

	logic                      busy_q;
	logic                      done_q;
	logic [lph_pkg::CNT_W-1:0] cnt_q;
	logic [lph_pkg::KEY_W-1:0] dvd_q;
	logic [DW-1:0]             dvs_q;
	logic [DW-1:0]             rem_q;
	logic [DW:0]               trial;
	logic [DW:0]               diff;

	assign trial = {rem_q, dvd_q[lph_pkg::KEY_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lph_pkg::CNT_W'(lph_pkg::KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[lph_pkg::KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[DW-1:0];
			end else begin
				rem_q <= trial[DW-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

### design/lph_mem.sv
// Slot store: one write port and one registered read port.
module lph_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  lph_pkg::entry_t       wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output lph_pkg::entry_t       rdata
);

	lph_pkg::entry_t mem [DEPTH];
	lph_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### test/tb_linear_probe_hash_table.sv
// Testbench for the linear probing hash table: directed and random requests.
module tb_linear_probe_hash_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 1024;

	// The package names three requests; the fourth code must be refused.
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	typedef struct packed {
		logic                       st;
		logic [lph_pkg::SLOT_W-1:0] slot;
	} answer_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [1:0]                 req_type = lph_pkg::OP_INSERT;
	logic [lph_pkg::KEY_W-1:0]  key_value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       status;
	logic [lph_pkg::SLOT_W-1:0] slot_index;
	logic                       cfg_wr_en = 1'b0;
	logic [lph_pkg::SIZE_W-1:0] cfg_wr_data = '0;

	// Local copy of the table: occupancy, keys and the size register.
	bit                         held[TABLE_DEPTH];
	bit [lph_pkg::KEY_W-1:0]    held_key[TABLE_DEPTH];
	bit [lph_pkg::SIZE_W-1:0]   size_reg = lph_pkg::SIZE_RESET;

	// Answers owed by the block, oldest first.
	answer_t                    answers_due[$];

	// Keys reused by the random requests so that searches and deletes hit.
	logic [lph_pkg::KEY_W-1:0]  key_pool[8];

	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	int                fail_count = 0;
	int                answer_count = 0;

	linear_probe_hash_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key_value  (key_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot_index (slot_index),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clamp the register the way the block does: 0 acts as 1, anything above
	// the depth acts as the depth.
	function automatic int live_span();
		if (size_reg == 0)
			return 1;
		if (size_reg > TABLE_DEPTH)
			return TABLE_DEPTH;
		return int'(size_reg);
	endfunction

	// Walk the table from the home slot, apply the request to the local copy
	// and return the answer the block must give.
	function automatic answer_t probe_table(input logic [1:0] op,
		input logic [lph_pkg::KEY_W-1:0] key);
		int      span;
		int      pos;
		int      hit;
		answer_t ans;
		span = live_span();
		pos = int'({1'b0, key} % span);
		hit = -1;
		if (op != OP_UNKNOWN) begin
			for (int i = 0; i < span && hit < 0; i++) begin
				if (op == lph_pkg::OP_INSERT) begin
					if (!held[pos])
						hit = pos;
				end else if (held[pos] && held_key[pos] == key) begin
					hit = pos;
				end
				pos = (pos + 1 == span) ? 0 : pos + 1;
			end
		end
		if (hit >= 0) begin
			case (op)
				lph_pkg::OP_INSERT: begin
					held[hit] = 1'b1;
					held_key[hit] = key;
				end
				lph_pkg::OP_DELETE: begin
					held[hit] = 1'b0;
					held_key[hit] = '0;
				end
				default: ;
			endcase
			ans.st = lph_pkg::ST_OK;
			ans.slot = lph_pkg::SLOT_W'(hit);
		end else begin
			ans.st = lph_pkg::ST_FAIL;
			ans.slot = '0;
		end
		return ans;
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%t: %s", $realtime, what);
	endtask

	// Result side: stall at random, and check every transfer against the
	// oldest answer owed.
	always @(posedge clk) begin : result_check
		answer_t due;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (answers_due.size() == 0) begin
				note_failure($sformatf("result with nothing owed: status %0b slot %0d",
					status, slot_index));
			end else begin
				due = answers_due.pop_front();
				if (status !== due.st || slot_index !== due.slot)
					note_failure($sformatf(
						"result %0d: status %0b slot %0d, wanted status %0b slot %0d",
						answer_count, status, slot_index, due.st, due.slot));
			end
			answer_count++;
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offer one request and hold it until the transfer; the model is updated
	// at the edge that takes it. Valid is left high so that a back-to-back
	// request follows without a gap.
	task automatic send_request(input logic [1:0] op, input logic [lph_pkg::KEY_W-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		key_value <= key;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		answers_due.push_back(probe_table(op, key));
	endtask

	task automatic wait_for_answers();
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	// Write the size register once the block has gone quiet.
	task automatic set_table_size(input logic [lph_pkg::SIZE_W-1:0] value);
		in_valid <= 1'b0;
		wait_for_answers();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		size_reg = value;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Reset size: smallest and largest keys, a collision, wrap from the last
	// slot, misses, a delete that leaves a hole, and the undefined request.
	task automatic test_key_extremes();
		send_request(lph_pkg::OP_INSERT, '0);
		send_request(lph_pkg::OP_INSERT, {lph_pkg::KEY_W{1'b1}});
		send_request(lph_pkg::OP_INSERT, lph_pkg::KEY_W'(1024));
		send_request(lph_pkg::OP_INSERT, lph_pkg::KEY_W'(2047));
		send_request(lph_pkg::OP_SEARCH, lph_pkg::KEY_W'(1024));
		send_request(lph_pkg::OP_SEARCH, lph_pkg::KEY_W'(5));
		send_request(lph_pkg::OP_DELETE, '0);
		send_request(lph_pkg::OP_SEARCH, lph_pkg::KEY_W'(1024));
		send_request(lph_pkg::OP_DELETE, lph_pkg::KEY_W'(12345));
		send_request(OP_UNKNOWN, {lph_pkg::KEY_W{1'b1}});
	endtask

	// Size 0 behaves as a single slot; an oversized value behaves as the
	// full depth and brings back the entries stored beyond slot 0.
	task automatic test_size_clamping();
		set_table_size('0);
		send_request(lph_pkg::OP_INSERT, lph_pkg::KEY_W'(5));
		send_request(lph_pkg::OP_INSERT, lph_pkg::KEY_W'(6));
		send_request(lph_pkg::OP_SEARCH, lph_pkg::KEY_W'(1024));
		set_table_size({lph_pkg::SIZE_W{1'b1}});
		send_request(lph_pkg::OP_SEARCH, lph_pkg::KEY_W'(1024));
		send_request(lph_pkg::OP_SEARCH, lph_pkg::KEY_W'(5));
		send_request(lph_pkg::OP_DELETE, lph_pkg::KEY_W'(5));
	endtask

	// Shrink over stored keys, fill what is left and overflow it.
	task automatic test_fill_and_shrink();
		set_table_size(lph_pkg::SIZE_W'(4));
		send_request(lph_pkg::OP_INSERT, lph_pkg::KEY_W'(4));
		send_request(lph_pkg::OP_INSERT, lph_pkg::KEY_W'(8));
		send_request(lph_pkg::OP_INSERT, lph_pkg::KEY_W'(9));
		send_request(lph_pkg::OP_SEARCH, lph_pkg::KEY_W'(2047));
		send_request(lph_pkg::OP_DELETE, lph_pkg::KEY_W'(1024));
	endtask

	// Mixed traffic at one size. Half the pool shares a home slot so that
	// probe chains form; most keys come from the pool, the rest are random.
	task automatic test_random_churn(input int size_value, input int count);
		logic [1:0]                op;
		logic [lph_pkg::KEY_W-1:0] key;
		int                        span;
		int                        base;
		int                        pick;
		set_table_size(lph_pkg::SIZE_W'(size_value));
		span = live_span();
		base = $urandom_range(32'h3FFF_FFFF);
		for (int i = 0; i < 8; i++) begin
			if (i < 4)
				key_pool[i] = lph_pkg::KEY_W'(base + i * span);
			else
				key_pool[i] = lph_pkg::KEY_W'($urandom());
		end
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				op = lph_pkg::OP_INSERT;
			else if (pick < 75)
				op = lph_pkg::OP_SEARCH;
			else if (pick < 95)
				op = lph_pkg::OP_DELETE;
			else
				op = OP_UNKNOWN;
			if ($urandom_range(99) < 75)
				key = key_pool[$urandom_range(7)];
			else
				key = lph_pkg::KEY_W'($urandom());
			send_request(op, key);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// Hold off until the clearing pass has emptied the store.
		do
			@(posedge clk);
		while (in_ready !== 1'b1);

		// Sender idles lightly, receiver stalls heavily.
		set_idling(21, 62);
		test_key_extremes();
		test_size_clamping();
		test_fill_and_shrink();
		test_random_churn(7, 140);
		test_random_churn(1, 20);

		// Swap the pressure round.
		set_idling(62, 21);
		test_random_churn(16, 140);
		test_random_churn(1023, 30);

		// Run flat out.
		set_idling(0, 0);
		test_random_churn(3, 90);
		test_random_churn(1024, 40);
		test_random_churn(64, 100);

		// Drain, then give the block time to show any stray transfer.
		in_valid <= 1'b0;
		wait_for_answers();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#25ms;
		$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
design/lph_pkg.sv
design/lph_div.sv
design/lph_mem.sv
design/linear_probe_hash_table.sv
test/tb_linear_probe_hash_table.sv
